### hdl/fbs_pkg.sv
// ----------------------------------------------------------------------------
// Face box smoother package
// Shared widths, register codes, payload types and the constant dividers used
// by the crop arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package fbs_pkg;

  localparam int COORD_W   = 13;
  localparam int BOX_W     = 9;
  localparam int NUM_EDGES = 4;

  localparam logic [COORD_W-1:0] COORD_MAX = 13'h1FFF;

  // Corner order inside an edge vector.
  localparam int EDGE_L = 0;
  localparam int EDGE_T = 1;
  localparam int EDGE_R = 2;
  localparam int EDGE_B = 3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  // Reciprocal constants: floor(n/10) for 13-bit n, floor(n/20) for 17-bit n.
  localparam int DIV10_SHIFT = 17;
  localparam logic [13:0] DIV10_MUL = 14'd13108;
  localparam int DIV10_P_W   = DIV10_SHIFT + COORD_W;
  localparam int DIV20_IN_W  = COORD_W + 4;
  localparam int DIV20_SHIFT = 22;
  localparam logic [17:0] DIV20_MUL = 18'd209716;

  typedef logic [NUM_EDGES-1:0][COORD_W-1:0] edge_t;

  typedef struct packed {
    logic             face_found;
    logic [BOX_W-1:0] box_left;
    logic [BOX_W-1:0] box_top;
    logic [BOX_W-1:0] box_width;
    logic [BOX_W-1:0] box_height;
  } box_t;

  // A smoothed box; ok low means the word yields an all-zero region.
  typedef struct packed {
    logic  ok;
    edge_t box;
  } smooth_t;

  function automatic logic [COORD_W-1:0] div10(input logic [COORD_W-1:0] n);
    logic [DIV10_P_W-1:0] p;
    begin
      p = DIV10_P_W'(n) * DIV10_P_W'(DIV10_MUL);
      return p[DIV10_SHIFT +: COORD_W];
    end
  endfunction

  function automatic logic [COORD_W-1:0] div20(input logic [DIV20_IN_W-1:0] n);
    logic [DIV20_IN_W+18-1:0] p;
    begin
      p = (DIV20_IN_W + 18)'(n) * (DIV20_IN_W + 18)'(DIV20_MUL);
      return p[DIV20_SHIFT +: COORD_W];
    end
  endfunction

endpackage

`default_nettype wire

### hdl/fbs_if.sv
// ----------------------------------------------------------------------------
// Face box smoother channels
// Valid/ready channels for the incoming face box and the outgoing region.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbs_box_if;
  logic                       valid;
  logic                       ready;
  logic                       face_found;
  logic [fbs_pkg::BOX_W-1:0]  box_left;
  logic [fbs_pkg::BOX_W-1:0]  box_top;
  logic [fbs_pkg::BOX_W-1:0]  box_width;
  logic [fbs_pkg::BOX_W-1:0]  box_height;

  modport source (output valid, face_found, box_left, box_top, box_width, box_height,
                  input ready);
  modport sink (input valid, face_found, box_left, box_top, box_width, box_height,
                output ready);
endinterface

interface fbs_roi_if;
  logic                         valid;
  logic                         ready;
  logic                         roi_valid;
  logic [fbs_pkg::COORD_W-1:0]  roi_left;
  logic [fbs_pkg::COORD_W-1:0]  roi_top;
  logic [fbs_pkg::COORD_W-1:0]  roi_width;
  logic [fbs_pkg::COORD_W-1:0]  roi_height;

  modport source (output valid, roi_valid, roi_left, roi_top, roi_width, roi_height,
                  input ready);
  modport sink (input valid, roi_valid, roi_left, roi_top, roi_width, roi_height,
                output ready);
endinterface

`default_nettype wire

### hdl/face_box_smoother_roi_crop_top.sv
// ----------------------------------------------------------------------------
// Face box smoother with region-of-interest crop
// One face box word per video frame enters on box_i; one region word leaves
// on roi_o for every box word, in order. Both channels move a word when
// valid and ready are high at a rising edge of clk_i.
// The box is scaled up, averaged over the last WINDOW stored boxes once the
// history is full, and cropped; a cropped right or bottom edge outside the frame
// set by the frame_width and frame_height registers (written through cfg_we_i,
// cfg_index_i and cfg_data_i) keeps its uncropped value. The user must write
// them only while no word is in flight; the block does not enforce it. A word
// is taken in every cycle while the receiver keeps ready high; its region goes
// through the input register, history stage, margin stage and output register.
// Reset empties the pipeline and the history and restores the frame size to
// 1920 by 1080. When the receiver holds ready low, each stage keeps its word
// and box_i stays ready until the four registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module face_box_smoother_roi_crop_top #(
  parameter int WINDOW  = 7,
  parameter int UPSCALE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fbs_pkg::COORD_W-1:0]   cfg_data_i,
  fbs_box_if.sink                       box_i,
  fbs_roi_if.source                     roi_o
);

  logic [fbs_pkg::COORD_W-1:0] frame_width_q;
  logic [fbs_pkg::COORD_W-1:0] frame_height_q;
  logic                        in_vld_q;
  fbs_pkg::box_t               in_q;
  logic                        hist_ready;
  logic                        smooth_vld;
  logic                        crop_ready;
  fbs_pkg::smooth_t            smooth;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= fbs_pkg::FRAME_WIDTH_RST;
      frame_height_q <= fbs_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fbs_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        fbs_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign box_i.ready = !in_vld_q || hist_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (box_i.ready) begin
      in_vld_q <= box_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_i.valid && box_i.ready) begin
      in_q.face_found <= box_i.face_found;
      in_q.box_left   <= box_i.box_left;
      in_q.box_top    <= box_i.box_top;
      in_q.box_width  <= box_i.box_width;
      in_q.box_height <= box_i.box_height;
    end
  end

  fbs_hist #(
    .WINDOW  (WINDOW),
    .UPSCALE (UPSCALE)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_vld_q),
    .in_ready_o  (hist_ready),
    .in_box_i    (in_q),
    .out_valid_o (smooth_vld),
    .out_ready_i (crop_ready),
    .out_box_o   (smooth)
  );

  fbs_crop u_crop (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (smooth_vld),
    .in_ready_o     (crop_ready),
    .in_box_i       (smooth),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .roi_o          (roi_o)
  );

endmodule

`default_nettype wire

### hdl/fbs_hist.sv
// ----------------------------------------------------------------------------
// Face box smoother history stage
// Scales the box to full resolution, keeps the ring of recent boxes with
// running corner sums, and registers either the box itself or the mean.
// ----------------------------------------------------------------------------
`default_nettype none

module fbs_hist #(
  parameter int WINDOW  = 7,
  parameter int UPSCALE = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fbs_pkg::box_t    in_box_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fbs_pkg::smooth_t out_box_o
);

  localparam int CW      = fbs_pkg::COORD_W;
  localparam int SW      = CW + $clog2(WINDOW);
  localparam int PTR_W   = $clog2(WINDOW);
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int PW      = 2 * SW + 1;
  localparam int DIV_K   = SW + $clog2(WINDOW);
  localparam int DIV_M_I = ((1 << DIV_K) + WINDOW - 1) / WINDOW;
  localparam logic [SW:0] DIV_M = (SW + 1)'(DIV_M_I);
  localparam int BW1     = fbs_pkg::BOX_W + 1;
  localparam int SCW_MIN = BW1 + $clog2(UPSCALE + 1);
  localparam int SCW     = (SCW_MIN > CW) ? SCW_MIN : CW;

  fbs_pkg::edge_t   hist_q [WINDOW];
  logic [SW-1:0]    sum_q [fbs_pkg::NUM_EDGES];
  logic [SW-1:0]    sum_d [fbs_pkg::NUM_EDGES];
  logic [SW:0]      acc [fbs_pkg::NUM_EDGES];
  logic [PW-1:0]    prod [fbs_pkg::NUM_EDGES];
  logic [PTR_W-1:0] pos_q;
  logic [FILL_W-1:0] fill_q;
  logic             vld_q;
  fbs_pkg::smooth_t res_q;
  fbs_pkg::edge_t   scaled;
  fbs_pkg::edge_t   mean;
  logic             full;
  logic             use_box;
  logic             adv;

  function automatic logic [CW-1:0] scale_sat(input logic [BW1-1:0] v);
    logic [SCW-1:0] p;
    begin
      p = SCW'(v) * SCW'(UPSCALE);
      return (p > SCW'(fbs_pkg::COORD_MAX)) ? fbs_pkg::COORD_MAX : p[CW-1:0];
    end
  endfunction

  assign in_ready_o  = !vld_q || out_ready_i;
  assign adv         = in_valid_i && in_ready_o;
  assign out_valid_o = vld_q;
  assign out_box_o   = res_q;

  always_comb begin
    scaled[fbs_pkg::EDGE_L] = scale_sat(BW1'(in_box_i.box_left));
    scaled[fbs_pkg::EDGE_T] = scale_sat(BW1'(in_box_i.box_top));
    scaled[fbs_pkg::EDGE_R] = scale_sat(BW1'(in_box_i.box_left) + BW1'(in_box_i.box_width));
    scaled[fbs_pkg::EDGE_B] = scale_sat(BW1'(in_box_i.box_top) + BW1'(in_box_i.box_height));
  end

  assign use_box = in_box_i.face_found
                   && (scaled[fbs_pkg::EDGE_R] > scaled[fbs_pkg::EDGE_L])
                   && (scaled[fbs_pkg::EDGE_B] > scaled[fbs_pkg::EDGE_T]);
  assign full    = (fill_q == FILL_W'(WINDOW));

  // The mean covers only the stored boxes; the incoming one replaces the
  // oldest entry afterwards, so the running sum drops that entry as well.
  always_comb begin
    for (int k = 0; k < fbs_pkg::NUM_EDGES; k++) begin
      prod[k]  = PW'(sum_q[k]) * PW'(DIV_M);
      mean[k]  = prod[k][DIV_K +: CW];
      acc[k]   = (SW + 1)'(sum_q[k]) + (SW + 1)'(scaled[k])
                 - (full ? (SW + 1)'(hist_q[pos_q][k]) : '0);
      sum_d[k] = acc[k][SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pos_q  <= '0;
      fill_q <= '0;
      for (int k = 0; k < fbs_pkg::NUM_EDGES; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (adv && use_box) begin
        for (int k = 0; k < fbs_pkg::NUM_EDGES; k++) begin
          sum_q[k] <= sum_d[k];
        end
        pos_q <= (pos_q == PTR_W'(WINDOW - 1)) ? '0 : pos_q + PTR_W'(1);
        if (!full) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && use_box) begin
      hist_q[pos_q] <= scaled;
    end
    if (adv) begin
      res_q.ok  <= use_box;
      res_q.box <= full ? mean : scaled;
    end
  end

endmodule

`default_nettype wire

### hdl/fbs_crop.sv
// ----------------------------------------------------------------------------
// Face box smoother crop stages
// Works out the crop margins of the smoothed box, then crops the edges, keeping
// the old right or bottom edge where the new one is outside the frame, and registers the region on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fbs_crop (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fbs_pkg::smooth_t            in_box_i,
  input  logic [fbs_pkg::COORD_W-1:0] frame_width_i,
  input  logic [fbs_pkg::COORD_W-1:0] frame_height_i,
  fbs_roi_if.source                   roi_o
);

  localparam int CW  = fbs_pkg::COORD_W;
  localparam int H11 = fbs_pkg::DIV20_IN_W;

  typedef struct packed {
    logic           ok;
    fbs_pkg::edge_t box;
    logic [CW-1:0]  q10;
    logic [CW-1:0]  q55;
    logic [CW-1:0]  q5;
  } crop_t;

  crop_t         mid_q;
  logic          mid_vld_q;
  logic          mid_ready;
  logic          out_vld_q;
  logic          out_ready;
  logic [CW-1:0] sl, st, sr, sb, w, h;
  logic [H11-1:0] h11;
  logic [CW-1:0] nl, nt, nr, nb, nr_c, nb_c;
  logic [CW-1:0] x0, x1, y0, y1;
  logic          roi_ok;
  logic          roi_valid_q;
  logic [CW-1:0] roi_left_q, roi_top_q, roi_width_q, roi_height_q;

  assign out_ready  = !out_vld_q || roi_o.ready;
  assign mid_ready  = !mid_vld_q || out_ready;
  assign in_ready_o = mid_ready;

  // Margins of the smoothed box.
  always_comb begin
    sl  = in_box_i.box[fbs_pkg::EDGE_L];
    st  = in_box_i.box[fbs_pkg::EDGE_T];
    sr  = in_box_i.box[fbs_pkg::EDGE_R];
    sb  = in_box_i.box[fbs_pkg::EDGE_B];
    w   = sr - sl;
    h   = sb - st;
    h11 = (H11'(h) << 3) + (H11'(h) << 1) + H11'(h);
  end

  // The left and top edges only move inwards, so the rule that keeps them
  // when they reach zero can never change them.
  always_comb begin
    nl   = mid_q.box[fbs_pkg::EDGE_L] + mid_q.q10;
    nt   = mid_q.box[fbs_pkg::EDGE_T] + mid_q.q55;
    nr   = mid_q.box[fbs_pkg::EDGE_R] - mid_q.q10;
    nb   = mid_q.box[fbs_pkg::EDGE_B] - mid_q.q5;
    nr_c = (nr >= frame_width_i) ? mid_q.box[fbs_pkg::EDGE_R] : nr;
    nb_c = (nb >= frame_height_i) ? mid_q.box[fbs_pkg::EDGE_B] : nb;
    x0   = (nl < nr_c) ? nl : nr_c;
    x1   = (nl < nr_c) ? nr_c : nl;
    y0   = (nt < nb_c) ? nt : nb_c;
    y1   = (nt < nb_c) ? nb_c : nt;
    roi_ok = mid_q.ok && (x1 != x0) && (y1 != y0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (mid_ready) begin
        mid_vld_q <= in_valid_i;
      end
      if (out_ready) begin
        out_vld_q <= mid_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && mid_ready) begin
      mid_q.ok  <= in_box_i.ok && (sr > sl) && (sb > st);
      mid_q.box <= in_box_i.box;
      mid_q.q10 <= fbs_pkg::div10(w);
      mid_q.q55 <= fbs_pkg::div20(h11);
      mid_q.q5  <= fbs_pkg::div20(H11'(h));
    end
    if (mid_vld_q && out_ready) begin
      roi_valid_q  <= roi_ok;
      roi_left_q   <= roi_ok ? x0 : '0;
      roi_top_q    <= roi_ok ? y0 : '0;
      roi_width_q  <= roi_ok ? x1 - x0 : '0;
      roi_height_q <= roi_ok ? y1 - y0 : '0;
    end
  end

  assign roi_o.valid      = out_vld_q;
  assign roi_o.roi_valid  = roi_valid_q;
  assign roi_o.roi_left   = roi_left_q;
  assign roi_o.roi_top    = roi_top_q;
  assign roi_o.roi_width  = roi_width_q;
  assign roi_o.roi_height = roi_height_q;

endmodule

`default_nettype wire
